@@ hw/rtl/wmf_pkg.sv @@
package wmf_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_HALF_SIZE    = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam int PIX_W  = 16;
  localparam int COL_W  = 11;  // columns stay below the clamped image width, at most LINE_WIDTH-1
  localparam int ROW_W  = 16;
  localparam int SLOT_W = 4;   // slot below 2*S, S at most 7
  localparam int CNT_W  = 8;   // window holds at most 4*7*7 values
  localparam int BIT_W  = 4;

  localparam logic [2:0] CAP_PIXEL = 3'd4;
  localparam logic [2:0] CAP_DRAIN = 3'd1;

  typedef struct packed {
    logic [2:0]       s;
    logic [COL_W-1:0] w;
    logic [ROW_W-1:0] h;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  col;
    logic [PIX_W-1:0]  data;
  } wr_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic              fin;
    logic              last;
  } job_t;

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic             last;
    logic             fin;
  } res_t;

endpackage

@@ hw/rtl/window_median_filter.sv @@
// Channel   Dir  Handshake               Payload
// in        in   push / full             action, pixel_value
// result    out  pop / empty             median_value, last_of_run, last_of_frame
// config    in   psel, penable, pwrite   paddr, pwdata, prdata (pready tied high)
//
// Each result takes 16 passes over the 4*S*S window values read from the line store,
//   one read a cycle; the single read port of the line store sets this pace.
// An item is taken only when the front is idle, the job queue is empty and the
//   back unit is idle; a pixel, if stored, is written into the line store in its accept cycle.
// Results wait in a four-deep queue; once it is full a stalled pop holds the back
//   unit, and with it the input side.
// Reset (rst, synchronous) clears counters and queues; the line store is not cleared.
module window_median_filter #(
  parameter int MAX_HALF   = 4,
  parameter int LINE_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic [15:0] pixel_value,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] median_value,
  output logic        last_of_run,
  output logic        last_of_frame,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [2:0]  half_size;
  logic [10:0] image_width;
  logic [15:0] image_height;
  logic        cfg_wr, reg_wr;

  wmf_pkg::cfg_t cfg;
  wmf_pkg::wr_t  wr;
  wmf_pkg::job_t job_w, job_r;
  wmf_pkg::res_t res_w, res_r;
  logic          job_push, job_pop, job_empty, job_full_unused;
  logic          res_push, res_full, back_idle;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  // a write inside the register list restarts the frame
  assign reg_wr = cfg_wr && (paddr[3:2] != 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_size    <= 3'd1;
      image_width  <= 11'd1024;
      image_height <= 16'd1024;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        wmf_pkg::REG_HALF_SIZE:    half_size    <= pwdata[2:0];
        wmf_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[10:0];
        wmf_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      wmf_pkg::REG_HALF_SIZE:    prdata = 32'(half_size);
      wmf_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      wmf_pkg::REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:                   prdata = '0;
    endcase
  end

  // effective values: S in 1..MAX_HALF, width in 1..LINE_WIDTH, height 0 as 1
  always_comb begin
    if (half_size == 3'd0) cfg.s = 3'd1;
    else if (int'(half_size) > MAX_HALF) cfg.s = 3'(MAX_HALF);
    else cfg.s = half_size;
    if (image_width == 11'd0) cfg.w = 11'd1;
    else if (int'(image_width) > LINE_WIDTH) cfg.w = 11'(LINE_WIDTH);
    else cfg.w = image_width;
    cfg.h = (image_height == 16'd0) ? 16'd1 : image_height;
  end

  wmf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cfg_wr      (reg_wr),
    .push        (push),
    .action      (action),
    .pixel_value (pixel_value),
    .job_empty   (job_empty),
    .back_idle   (back_idle),
    .full        (full),
    .wr          (wr),
    .job_push    (job_push),
    .job         (job_w)
  );

  // at most four jobs per request into an empty queue: never overflows
  wmf_queue #(.WIDTH($bits(wmf_pkg::job_t)), .DEPTH(4)) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (job_push),
    .wdata (job_w),
    .rd    (job_pop),
    .rdata (job_r),
    .empty (job_empty),
    .full  (job_full_unused)
  );

  wmf_back #(.MAX_HALF(MAX_HALF), .LINE_WIDTH(LINE_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .wr        (wr),
    .job_empty (job_empty),
    .job_in    (job_r),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_w),
    .idle      (back_idle)
  );

  wmf_queue #(.WIDTH($bits(wmf_pkg::res_t)), .DEPTH(4)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res_w),
    .rd    (pop),
    .rdata (res_r),
    .empty (empty),
    .full  (res_full)
  );

  assign median_value  = res_r.median;
  assign last_of_run   = res_r.last;
  assign last_of_frame = res_r.fin;
endmodule

@@ hw/rtl/wmf_queue.sv @@
module wmf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [PW:0]      count;

  assign empty = (count == '0);
  assign full  = (count == (PW+1)'(DEPTH));
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= (wptr == PW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= (rptr == PW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PW+1)'(wr && !full) - (PW+1)'(rd && !empty);
    end
  end
endmodule

@@ hw/rtl/wmf_front.sv @@
module wmf_front (
  input  logic                       clk,
  input  logic                       rst,
  input  wmf_pkg::cfg_t              cfg,
  input  logic                       cfg_wr,
  input  logic                       push,
  input  logic                       action,
  input  logic [wmf_pkg::PIX_W-1:0]  pixel_value,
  input  logic                       job_empty,
  input  logic                       back_idle,
  output logic                       full,
  output wmf_pkg::wr_t               wr,
  output logic                       job_push,
  output wmf_pkg::job_t              job
);
  typedef enum logic [1:0] {F_IDLE = 2'b01, F_EMIT = 2'b10} fstate_t;

  fstate_t state;
  logic [wmf_pkg::COL_W-1:0]  icol, ocol;
  logic [wmf_pkg::ROW_W-1:0]  irow, orow;
  logic [wmf_pkg::SLOT_W-1:0] islot, oslot, slot_top;
  logic [2:0]                 ecnt, cap;
  wmf_pkg::job_t              pend;
  logic                       pend_v;

  logic [16:0] ry;
  logic [11:0] cx;
  logic        ready, accept, write_px, take, fin;

  assign slot_top = wmf_pkg::SLOT_W'({cfg.s, 1'b0} - 4'd1);

  always_comb begin
    ry = {1'b0, orow} + 17'(cfg.s) - 17'd1;
    if (ry > 17'(cfg.h) - 17'd1) ry = 17'(cfg.h) - 17'd1;
    cx = {1'b0, ocol} + 12'(cfg.s) - 12'd1;
    if (cx > 12'(cfg.w) - 12'd1) cx = 12'(cfg.w) - 12'd1;
    ready = (orow < cfg.h) && (ocol < cfg.w) &&
            ((17'(irow) > ry) || ((17'(irow) == ry) && (12'(icol) > cx)));
  end

  assign full     = !((state == F_IDLE) && job_empty && back_idle);
  assign accept   = push && !full;
  assign write_px = accept && !action && !ready && (irow < cfg.h);
  assign take     = (state == F_EMIT) && ready && (ecnt < cap);
  assign fin      = (orow == cfg.h - 1'b1) && (ocol == cfg.w - 1'b1);

  assign wr.en   = write_px;
  assign wr.slot = islot;
  assign wr.col  = icol;
  assign wr.data = pixel_value;

  assign job_push = (state == F_EMIT) && pend_v;
  always_comb begin
    job      = pend;
    job.last = !take;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      icol  <= '0;
      irow  <= '0;
      islot <= '0;
      ocol  <= '0;
      orow  <= '0;
      oslot <= '0;
    end else if (write_px) begin
      if (icol + 1'b1 >= cfg.w) begin
        icol  <= '0;
        irow  <= irow + 1'b1;
        islot <= (islot == slot_top) ? '0 : islot + 1'b1;
      end else begin
        icol <= icol + 1'b1;
      end
    end else if (take) begin
      if (fin) begin
        // final pixel of the frame: next pixel starts a new frame
        icol  <= '0;
        irow  <= '0;
        islot <= '0;
        ocol  <= '0;
        orow  <= '0;
        oslot <= '0;
      end else if (ocol + 1'b1 >= cfg.w) begin
        ocol  <= '0;
        orow  <= orow + 1'b1;
        oslot <= (oslot == slot_top) ? '0 : oslot + 1'b1;
      end else begin
        ocol <= ocol + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      pend_v <= 1'b0;
      ecnt   <= '0;
      cap    <= wmf_pkg::CAP_PIXEL;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            state  <= F_EMIT;
            ecnt   <= '0;
            pend_v <= 1'b0;
            cap    <= action ? wmf_pkg::CAP_DRAIN : wmf_pkg::CAP_PIXEL;
          end
        end
        F_EMIT: begin
          if (take) begin
            pend_v    <= 1'b1;
            pend.row  <= orow;
            pend.col  <= ocol;
            pend.slot <= oslot;
            pend.fin  <= fin;
            pend.last <= 1'b0;
            ecnt      <= ecnt + 1'b1;
          end else begin
            pend_v <= 1'b0;
            state  <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/wmf_back.sv @@
module wmf_back #(
  parameter int MAX_HALF   = 4,
  parameter int LINE_WIDTH = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  wmf_pkg::cfg_t cfg,
  input  wmf_pkg::wr_t  wr,
  input  logic          job_empty,
  input  wmf_pkg::job_t job_in,
  output logic          job_pop,
  input  logic          res_full,
  output logic          res_push,
  output wmf_pkg::res_t res,
  output logic          idle
);
  localparam int DEPTH = 2 * MAX_HALF * LINE_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    B_IDLE    = 5'b00001,
    B_ISSUE   = 5'b00010,
    B_WAIT    = 5'b00100,
    B_RESOLVE = 5'b01000,
    B_OUT     = 5'b10000
  } bstate_t;

  logic [wmf_pkg::PIX_W-1:0] line_store [DEPTH];

  bstate_t                    state;
  wmf_pkg::job_t              job;
  logic [wmf_pkg::SLOT_W-1:0] pi, pj, span_top, slotv;
  logic [wmf_pkg::BIT_W-1:0]  b;
  logic [wmf_pkg::PIX_W-1:0]  prefix, rdata, hi_mask;
  logic [wmf_pkg::CNT_W-1:0]  k, cnt;
  logic                       rvalid, match;
  logic signed [17:0]         r, c, delta, t, two_s;
  logic [wmf_pkg::COL_W-1:0]  colv;
  logic [AW-1:0]              raddr, waddr;

  assign span_top = wmf_pkg::SLOT_W'({cfg.s, 1'b0} - 4'd1);
  assign two_s    = 18'({cfg.s, 1'b0});

  // clamped window coordinates and the ring slot of the clamped row
  always_comb begin
    r = 18'(job.row) + 18'(pi) - 18'(cfg.s);
    if (r < 0) r = '0;
    else if (r > 18'(cfg.h) - 18'sd1) r = 18'(cfg.h) - 18'sd1;
    delta = r - 18'(job.row);
    t = 18'(job.slot) + delta;
    if (t < 0) t = t + two_s;
    else if (t >= two_s) t = t - two_s;
    slotv = t[wmf_pkg::SLOT_W-1:0];
    c = 18'(job.col) + 18'(pj) - 18'(cfg.s);
    if (c < 0) c = '0;
    else if (c > 18'(cfg.w) - 18'sd1) c = 18'(cfg.w) - 18'sd1;
    colv = c[wmf_pkg::COL_W-1:0];
  end

  assign raddr = AW'(int'(slotv) * LINE_WIDTH + int'(colv));
  assign waddr = AW'(int'(wr.slot) * LINE_WIDTH + int'(wr.col));

  always_ff @(posedge clk) begin
    if (wr.en) begin
      line_store[waddr] <= wr.data;
    end
    rdata <= line_store[raddr];
  end

  assign hi_mask = wmf_pkg::PIX_W'(17'h1ffff << (5'(b) + 5'd1));
  assign match   = (((rdata ^ prefix) & hi_mask) == '0) && !rdata[b];

  assign idle       = (state == B_IDLE);
  assign job_pop    = idle && !job_empty;
  assign res_push   = (state == B_OUT) && !res_full;
  assign res.median = prefix;
  assign res.last   = job.last;
  assign res.fin    = job.fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      rvalid <= 1'b0;
    end else begin
      rvalid <= (state == B_ISSUE);
      if (rvalid && match) cnt <= cnt + 1'b1;
      case (state)
        B_IDLE: begin
          if (!job_empty) begin
            job    <= job_in;
            pi     <= '0;
            pj     <= '0;
            b      <= '1;
            prefix <= '0;
            cnt    <= '0;
            k      <= wmf_pkg::CNT_W'(2 * int'(cfg.s) * int'(cfg.s) - 1);
            state  <= B_ISSUE;
          end
        end
        B_ISSUE: begin
          if (pj == span_top) begin
            pj <= '0;
            if (pi == span_top) begin
              pi    <= '0;
              state <= B_WAIT;
            end else begin
              pi <= pi + 1'b1;
            end
          end else begin
            pj <= pj + 1'b1;
          end
        end
        B_WAIT: state <= B_RESOLVE;
        B_RESOLVE: begin
          // more values below the candidate than the rank: bit stays 0
          if (cnt <= k) begin
            k         <= k - cnt;
            prefix[b] <= 1'b1;
          end
          cnt <= '0;
          if (b == '0) begin
            state <= B_OUT;
          end else begin
            b     <= b - 1'b1;
            state <= B_ISSUE;
          end
        end
        B_OUT: begin
          if (!res_full) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

@@ verif/window_median_filter_tb.sv @@
`timescale 1ns / 1ps

module window_median_filter_tb;

  // one expected result off the output queue
  typedef struct {
    logic [15:0] median;
    logic        last;
    logic        fin;
  } median_res_t;

  // Scoreboard: tracks the block's state and queues the expected medians
  // at the point each request is taken.
  class median_scoreboard;
    logic [15:0]     store [8192];
    int unsigned     in_col, in_row, out_col, out_row;
    int unsigned     half, width, height;
    median_res_t     due [$];
    int              errors, results, frames;

    function void clear_pos();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endfunction

    function void reset_state();
      clear_pos();
      half = 1; width = 1024; height = 1024;
      due.delete();
    endfunction

    function int unsigned eff_s();
      return (half < 1) ? 1 : (half > 4) ? 4 : half;
    endfunction
    function int unsigned eff_w();
      return (width < 1) ? 1 : (width > 1024) ? 1024 : width;
    endfunction
    function int unsigned eff_h();
      return (height < 1) ? 1 : height;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        wmf_pkg::REG_HALF_SIZE:    half = val[2:0];
        wmf_pkg::REG_IMAGE_WIDTH:  width = val[10:0];
        wmf_pkg::REG_IMAGE_HEIGHT: height = val[15:0];
        default: return;
      endcase
      clear_pos();
    endfunction

    // next output's clamped window fully arrived?
    function bit ready();
      int unsigned ry, cx;
      if (out_row >= eff_h() || out_col >= eff_w()) return 0;
      ry = out_row + eff_s() - 1;
      if (ry > eff_h() - 1) ry = eff_h() - 1;
      cx = out_col + eff_s() - 1;
      if (cx > eff_w() - 1) cx = eff_w() - 1;
      return (in_row > ry) || (in_row == ry && in_col > cx);
    endfunction

    function logic [15:0] median_at(int y, int c);
      logic [15:0] vals [$];
      int s, w, h, ry, cx;
      s = eff_s(); w = eff_w(); h = eff_h();
      for (int py = -s; py < s; py++) begin
        ry = y + py;
        if (ry < 0) ry = 0;
        if (ry > h - 1) ry = h - 1;
        for (int px = -s; px < s; px++) begin
          cx = c + px;
          if (cx < 0) cx = 0;
          if (cx > w - 1) cx = w - 1;
          vals.push_back(store[(ry % (2 * s)) * 1024 + cx]);
        end
      end
      vals.sort();
      return vals[2 * s * s - 1];
    endfunction

    // request taken: update state, queue the medians it releases
    function void note_request(logic act, logic [15:0] pix);
      int cap, cnt;
      median_res_t r;
      bit final_px;
      cap = act ? wmf_pkg::CAP_DRAIN : wmf_pkg::CAP_PIXEL;
      cnt = 0;
      if (!act && !ready() && in_row < eff_h()) begin
        store[(in_row % (2 * eff_s())) * 1024 + in_col] = pix;
        in_col++;
        if (in_col >= eff_w()) begin
          in_col = 0;
          in_row++;
        end
      end
      while (cnt < cap && ready()) begin
        final_px = (out_row == eff_h() - 1) && (out_col == eff_w() - 1);
        r.median = median_at(out_row, out_col);
        r.last = 0;
        r.fin = final_px;
        due.push_back(r);
        out_col++;
        if (out_col >= eff_w()) begin
          out_col = 0;
          out_row++;
        end
        if (final_px) begin
          clear_pos();
          frames++;
        end
        cnt++;
      end
      if (cnt > 0) due[$].last = 1;
    endfunction

    function void check_result(logic [15:0] m, logic l, logic f);
      median_res_t e;
      results++;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: median %h last %b frame %b", m, l, f);
        return;
      end
      e = due.pop_front();
      if (m !== e.median || l !== e.last || f !== e.fin) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp median %h last %b frame %b, got %h %b %b",
                   e.median, e.last, e.fin, m, l, f);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  logic        full;
  logic        action = 0;
  logic [15:0] pixel_value = 0;
  logic        empty;
  logic        pop = 0;
  logic [15:0] median_value;
  logic        last_of_run;
  logic        last_of_frame;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  window_median_filter uut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  median_scoreboard sb = new();
  bit  calm = 0;       // no idling on either side while set
  int  quiet = 0;      // watchdog: cycles with nothing accepted
  int  taken = 0;
  localparam int QUIET_LIMIT = 40000;

  // Monitor: everything sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        sb.note_request(action, pixel_value);
        taken++;
      end
      if (pop && !empty)
        sb.check_result(median_value, last_of_run, last_of_frame);
      if (psel && penable && pwrite && pready)
        sb.set_reg(paddr[3:2], pwdata);
      if ((push && !full) || (pop && !empty) || (psel && penable && pwrite && pready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
        $display("window_median_filter regression: fail");
        $finish;
      end
    end
  end

  // result side: random pop stalls
  always @(negedge clk)
    pop = calm || ($urandom_range(99) >= 36);

  // One request; starts and ends at a falling edge.
  task automatic send(input logic act, input logic [15:0] pix);
    bit ok;
    while (!calm && $urandom_range(99) < 36) begin
      push = 0;
      @(negedge clk);
    end
    push = 1;
    action = act;
    pixel_value = pix;
    ok = 0;
    while (!ok) begin
      @(posedge clk);
      ok = !full;
    end
    @(negedge clk);
  endtask

  task automatic wait_settled();
    push = 0;
    while (sb.due.size() != 0) @(negedge clk);
    // extra margin with push held low before returning
    repeat (1200) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    wait_settled();
    psel = 1; pwrite = 1; penable = 0;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic set_frame(input int s, input int w, input int h);
    write_reg(wmf_pkg::REG_HALF_SIZE, s);
    write_reg(wmf_pkg::REG_IMAGE_WIDTH, w);
    write_reg(wmf_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  function automatic logic [15:0] rand_pix();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed frame: pixels while nothing is ready, drains to flush.
  // A little noise: stray drains and pixels sent while outputs are ready.
  task automatic run_frame();
    int start, guard;
    start = sb.frames;
    guard = 0;
    while (sb.frames == start && guard < 200) begin
      if ($urandom_range(99) < 8)
        send(1'($urandom_range(1)), rand_pix());
      else
        send(sb.ready(), rand_pix());
      guard++;
    end
  endtask

  initial begin
    int rand_items;
    repeat (4) @(negedge clk);
    rst = 0;

    // directed: reset settings, S=1 over a wide row
    send(0, 16'h0000);
    send(0, 16'hffff);
    send(1, 16'h1234);
    send(0, 16'h8000);
    // half size 0 and height 0 clamp to 1; single-pixel frames
    set_frame(0, 1, 0);
    send(1, 16'h0000);          // drain with nothing ready
    send(0, 16'hffff);
    send(0, 16'h0000);
    // half size 7 clamps to 4; tiny frame, flush with drains
    set_frame(7, 3, 2);
    send(0, 16'hffff); send(0, 16'h0000); send(0, 16'haaaa);
    send(0, 16'h5555); send(0, 16'h0001);
    send(0, 16'hfffe);          // last pixel of the frame, releases the first outputs
    repeat (4) send(1, 16'hffff);
    // width over range clamps to 1024, tallest frame
    set_frame(2, 2047, 65535);
    repeat (4) send(0, rand_pix());
    set_frame(1, 1024, 65535);
    send(0, 16'h7fff); send(1, 16'h0000);

    // random frames
    rand_items = taken;
    while (taken < 210) begin
      if ($urandom_range(9) == 0)
        set_frame($urandom_range(7), $urandom_range(8), $urandom_range(6));
      else
        set_frame($urandom_range(1, 4), $urandom_range(1, 8), $urandom_range(1, 6));
      calm = (taken - rand_items > 60 && taken - rand_items < 110);
      run_frame();
      if ($urandom_range(4) == 0) begin
        // hold the sender until the block has delivered everything
        push = 0;
        while (sb.due.size() != 0) @(negedge clk);
      end
    end
    calm = 0;

    wait_settled();
    $display("covered %0d requests, %0d medians, %0d complete frames",
             taken, sb.results, sb.frames);
    $display("window sizes 1..4 with clamped register values, frames up to 8x6");
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("window_median_filter regression: pass");
    end else begin
      $display("%0d errors, %0d results outstanding", sb.errors, sb.due.size());
      $display("window_median_filter regression: fail");
    end
    $finish;
  end

  initial sb.reset_state();

endmodule

@@ files.f @@
hw/rtl/wmf_pkg.sv
hw/rtl/wmf_queue.sv
hw/rtl/wmf_front.sv
hw/rtl/wmf_back.sv
hw/rtl/window_median_filter.sv
verif/window_median_filter_tb.sv
